/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define HCB_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Condition that must never be true outside reset.
`define HCB_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

/* rtl/hcb_pkg.sv */
`default_nettype none
package hcb_pkg;

  localparam int MAX_CELLS_ACROSS = 64;
  localparam int NUM_BINS         = 9;
  localparam int BLOCK_CELLS      = 2;
  localparam int ELEMENTS         = BLOCK_CELLS * BLOCK_CELLS * NUM_BINS;
  localparam int ACROSS_LIMIT     = (MAX_CELLS_ACROSS < 64) ? MAX_CELLS_ACROSS : 64;
  localparam int COL_W            = $clog2(MAX_CELLS_ACROSS);
  localparam int BIN_W            = 4;
  localparam int HIST_W           = 21;
  localparam int MAG_W            = 13;
  localparam int POS_W            = 10;
  localparam int SUM_W            = 27;
  localparam int VALUE_W          = 17;
  localparam int IDX_W            = 6;
  localparam int QUEUE_DEPTH      = 2;
  localparam int ADDR_W           = 1 + COL_W + BIN_W;

  localparam logic [HIST_W-1:0] HIST_MAX = {HIST_W{1'b1}};

  localparam logic [1:0] CFG_CELL_SIZE    = 2'd0;
  localparam logic [1:0] CFG_CELLS_ACROSS = 2'd1;
  localparam logic [1:0] CFG_CELLS_DOWN   = 2'd2;

  typedef struct packed {
    logic [4:0] cell_size;
    logic [6:0] cells_across;
    logic [6:0] cells_down;
  } cfg_t;

  typedef struct packed {
    logic             slot;
    logic [COL_W-1:0] col;
    logic [BIN_W-1:0] bin;
    logic [MAG_W-1:0] mag;
    logic             first;
    logic             emit;
    logic [IDX_W-1:0] top;
    logic [IDX_W-1:0] lft;
  } op_t;

  typedef enum logic [1:0] {F_IDLE, F_CALC, F_PUSH} front_state_e;

  typedef enum logic [3:0] {
    B_IDLE, B_CLEAR, B_READ, B_WRITE, B_SUM_RD, B_SUM_ACC,
    B_VAL_RD, B_VAL_LD, B_DIV, B_OUT
  } back_state_e;

  // Cosine and sine of the sector test angles 20, 40, 60 and 80 degrees, Q0.16.
  function automatic logic [15:0] test_cos(logic [1:0] i);
    logic [15:0] r;
    case (i)
      2'd0:    r = 16'd61584;
      2'd1:    r = 16'd50203;
      2'd2:    r = 16'd32768;
      default: r = 16'd11380;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] test_sin(logic [1:0] i);
    logic [15:0] r;
    case (i)
      2'd0:    r = 16'd22415;
      2'd1:    r = 16'd42126;
      2'd2:    r = 16'd56756;
      default: r = 16'd64540;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/hcb_front.sv */
`default_nettype none
module hcb_front (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  hcb_pkg::cfg_t      cfg_i,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  wire  [7:0]         left_pixel_i,
  input  wire  [7:0]         right_pixel_i,
  input  wire  [7:0]         above_pixel_i,
  input  wire  [7:0]         below_pixel_i,
  input  wire                frame_start_i,
  output logic               push_valid_o,
  input  wire                push_ready_i,
  output hcb_pkg::op_t       push_op_o
);

  localparam int POS_W = hcb_pkg::POS_W;
  localparam int MAG_W = hcb_pkg::MAG_W;
  localparam int V_W   = 2 * MAG_W - 1;

  hcb_pkg::front_state_e state_q, state_d;

  logic [3:0]       step_q;
  logic [POS_W-1:0] col_q, row_q;
  logic [7:0]       ax_q, ay_q;
  logic             gxneg_q, gyneg_q, zero_q;
  logic [V_W-1:0]   v_q;
  logic [MAG_W-1:0] root_q;
  logic [3:0]       tests_q;
  logic [POS_W-1:0] cn_q, rn_q, cq_q, rq_q;
  logic [4:0]       cr_q, rr_q;

  // Clamped geometry.
  logic [4:0]  cs;
  logic [6:0]  across, down;
  logic [11:0] wide, high;

  always_comb begin
    if (cfg_i.cell_size < 5'd2) cs = 5'd2;
    else if (cfg_i.cell_size > 5'd16) cs = 5'd16;
    else cs = cfg_i.cell_size;
    if (cfg_i.cells_across < 7'd2) across = 7'd2;
    else if (cfg_i.cells_across > 7'(hcb_pkg::ACROSS_LIMIT)) across = 7'(hcb_pkg::ACROSS_LIMIT);
    else across = cfg_i.cells_across;
    if (cfg_i.cells_down < 7'd2) down = 7'd2;
    else if (cfg_i.cells_down > 7'd64) down = 7'd64;
    else down = cfg_i.cells_down;
    wide = 12'(across * cs);
    high = 12'(down * cs);
  end

  // Gradient and position at acceptance.
  logic signed [8:0] gx, gy;
  logic [7:0]        ax, ay;
  logic [16:0]       sq;
  logic [POS_W-1:0]  c0, r0;
  logic [POS_W:0]    c1, r1;

  always_comb begin
    gx = $signed({1'b0, right_pixel_i}) - $signed({1'b0, left_pixel_i});
    gy = $signed({1'b0, above_pixel_i}) - $signed({1'b0, below_pixel_i});
    ax = gx[8] ? 8'(-gx) : gx[7:0];
    ay = gy[8] ? 8'(-gy) : gy[7:0];
    sq = 17'(ax * ax) + 17'(ay * ay);
    c0 = frame_start_i ? '0 : col_q;
    r0 = frame_start_i ? '0 : row_q;
    if (12'(c0) >= wide) c0 = '0;
    if (12'(r0) >= high) r0 = '0;
    c1 = {1'b0, c0} + 1'b1;
    r1 = {1'b0, r0} + 1'b1;
  end

  wire accept = (state_q == hcb_pkg::F_IDLE) && in_valid_i;

  // One step of the square root, the two cell divisions and a sector test.
  logic [MAG_W-1:0]   cand;
  logic [2*MAG_W-1:0] cand_sq;
  logic [5:0]         cr2, rr2;
  logic [1:0]         tsel;
  logic               test_bit;

  always_comb begin
    cand     = root_q | (MAG_W'(1) << (MAG_W - 1 - step_q));
    cand_sq  = cand * cand;
    cr2      = {cr_q, cn_q[POS_W-1]};
    rr2      = {rr_q, rn_q[POS_W-1]};
    tsel     = step_q[1:0];
    test_bit = (24'(ay_q * hcb_pkg::test_cos(tsel))) >= (24'(ax_q * hcb_pkg::test_sin(tsel)));
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      hcb_pkg::F_IDLE: if (in_valid_i) state_d = hcb_pkg::F_CALC;
      hcb_pkg::F_CALC: if (step_q == 4'(MAG_W - 1)) state_d = hcb_pkg::F_PUSH;
      hcb_pkg::F_PUSH: if (push_ready_i) state_d = hcb_pkg::F_IDLE;
      default:         state_d = hcb_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hcb_pkg::F_IDLE;
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        if (12'(c1) >= wide) begin
          col_q <= '0;
          row_q <= (12'(r1) >= high) ? '0 : r1[POS_W-1:0];
        end else begin
          col_q <= c1[POS_W-1:0];
          row_q <= r0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ax_q    <= ax;
      ay_q    <= ay;
      gxneg_q <= gx[8];
      gyneg_q <= gy[8];
      zero_q  <= (gx == 9'sd0) && (gy == 9'sd0);
      v_q     <= {sq, 8'b0};
      root_q  <= '0;
      step_q  <= '0;
      cn_q    <= c0;
      rn_q    <= r0;
      cq_q    <= '0;
      rq_q    <= '0;
      cr_q    <= '0;
      rr_q    <= '0;
    end else if (state_q == hcb_pkg::F_CALC) begin
      step_q <= step_q + 4'd1;
      if ((V_W + 1)'(cand_sq) <= (V_W + 1)'(v_q)) root_q <= cand;
      if (step_q < 4'd4) tests_q[tsel] <= test_bit;
      if (step_q < 4'(POS_W)) begin
        cn_q <= cn_q << 1;
        rn_q <= rn_q << 1;
        if (cr2 >= {1'b0, cs}) begin
          cr_q <= 5'(cr2 - {1'b0, cs});
          cq_q <= {cq_q[POS_W-2:0], 1'b1};
        end else begin
          cr_q <= cr2[4:0];
          cq_q <= {cq_q[POS_W-2:0], 1'b0};
        end
        if (rr2 >= {1'b0, cs}) begin
          rr_q <= 5'(rr2 - {1'b0, cs});
          rq_q <= {rq_q[POS_W-2:0], 1'b1};
        end else begin
          rr_q <= rr2[4:0];
          rq_q <= {rq_q[POS_W-2:0], 1'b0};
        end
      end
    end
  end

  // Orientation bin from the folded sector tests and the gradient signs.
  logic [3:0] bin;
  always_comb begin
    if (zero_q) bin = 4'd4;
    else if (!gyneg_q) begin
      if (!gxneg_q) bin = !tests_q[0] ? 4'd4 : (!tests_q[2] ? 4'd5 : 4'd6);
      else bin = tests_q[3] ? 4'd6 : (tests_q[1] ? 4'd7 : 4'd8);
    end else begin
      if (!gxneg_q) bin = !tests_q[0] ? 4'd4 : (!tests_q[2] ? 4'd3 : 4'd2);
      else bin = tests_q[3] ? 4'd2 : (tests_q[1] ? 4'd1 : 4'd0);
    end
  end

  always_comb begin
    in_ready_o       = (state_q == hcb_pkg::F_IDLE);
    push_valid_o     = (state_q == hcb_pkg::F_PUSH);
    push_op_o.slot   = rq_q[0];
    push_op_o.col    = cq_q[hcb_pkg::COL_W-1:0];
    push_op_o.bin    = bin;
    push_op_o.mag    = root_q;
    push_op_o.first  = (cr_q == 5'd0) && (rr_q == 5'd0);
    push_op_o.emit   = (cr_q == cs - 5'd1) && (rr_q == cs - 5'd1) &&
                       (cq_q != '0) && (rq_q != '0);
    push_op_o.top    = 6'(rq_q - POS_W'(1));
    push_op_o.lft    = 6'(cq_q - POS_W'(1));
  end

endmodule
`default_nettype wire

/* rtl/hcb_fifo.sv */
`default_nettype none
`include "assert_macros.svh"
module hcb_fifo (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           push_valid_i,
  output logic          push_ready_o,
  input  hcb_pkg::op_t  push_op_i,
  output logic          pop_valid_o,
  input  wire           pop_ready_i,
  output hcb_pkg::op_t  pop_op_o
);

  localparam int DEPTH = hcb_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  hcb_pkg::op_t     slots_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] count_q;

  wire push = push_valid_i && push_ready_o;
  wire pop  = pop_valid_o && pop_ready_i;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_op_o     = slots_q[rptr_q];

  function automatic logic [PTR_W-1:0] bump(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push) wptr_q <= bump(wptr_q);
      if (pop) rptr_q <= bump(rptr_q);
      if (push && !pop) count_q <= count_q + CNT_W'(1);
      else if (pop && !push) count_q <= count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) slots_q[wptr_q] <= push_op_i;
  end

  `HCB_ASSERT_NEVER(a_count_range, clk_i, rst_ni, count_q > CNT_W'(DEPTH))
  `HCB_ASSERT(a_count_grow, clk_i, rst_ni, (push && !pop) |=> (count_q == $past(count_q) + CNT_W'(1)))

endmodule
`default_nettype wire

/* rtl/hcb_back.sv */
`default_nettype none
`include "assert_macros.svh"
module hcb_back (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           pop_valid_i,
  output logic          pop_ready_o,
  input  hcb_pkg::op_t  pop_op_i,
  output logic          out_valid_o,
  input  wire           out_ready_i,
  output logic [5:0]    block_row_o,
  output logic [5:0]    block_col_o,
  output logic [5:0]    element_o,
  output logic [16:0]   value_o,
  output logic          last_o
);

  localparam int HIST_W  = hcb_pkg::HIST_W;
  localparam int SUM_W   = hcb_pkg::SUM_W;
  localparam int VALUE_W = hcb_pkg::VALUE_W;
  localparam int ADDR_W  = hcb_pkg::ADDR_W;
  localparam int COL_W   = hcb_pkg::COL_W;
  localparam int NUM_W   = HIST_W + 16;

  hcb_pkg::back_state_e state_q, state_d;
  hcb_pkg::op_t         op_q;

  logic [HIST_W-1:0]  mem [2**ADDR_W];
  logic [HIST_W-1:0]  rdata_q;
  logic [ADDR_W-1:0]  raddr, waddr;
  logic [HIST_W-1:0]  wdata;
  logic               we;

  logic [3:0]         k_q, b_q;
  logic [1:0]         c_q;
  logic [5:0]         e_q;
  logic [SUM_W-1:0]   sum_q;
  logic [SUM_W-1:0]   rem_q;
  logic [VALUE_W-1:0] nlo_q, quo_q;
  logic [4:0]         dstep_q;

  wire out_free   = !out_valid_o || out_ready_i;
  wire last_elem  = (e_q == 6'(hcb_pkg::ELEMENTS - 1));

  // Histogram address of the current block element.
  logic [COL_W-1:0]  ecol;
  logic              eslot;
  logic [ADDR_W-1:0] eaddr;
  always_comb begin
    ecol  = op_q.lft[COL_W-1:0] + COL_W'(c_q[0]);
    eslot = op_q.top[0] ^ c_q[1];
    eaddr = {eslot, ecol, b_q};
  end

  logic [HIST_W:0]   added;
  logic [NUM_W-1:0]  num;
  logic [SUM_W:0]    r2;
  always_comb begin
    added = {1'b0, rdata_q} + (HIST_W + 1)'(op_q.mag);
    num   = {rdata_q, 16'b0} + NUM_W'(sum_q >> 1);
    r2    = {rem_q, nlo_q[VALUE_W-1]};
  end

  always_comb begin
    raddr = eaddr;
    waddr = {op_q.slot, op_q.col, k_q};
    wdata = (k_q == op_q.bin) ? HIST_W'(op_q.mag) : '0;
    we    = (state_q == hcb_pkg::B_CLEAR);
    pop_ready_o = (state_q == hcb_pkg::B_IDLE);
    if (state_q == hcb_pkg::B_READ) raddr = {op_q.slot, op_q.col, op_q.bin};
    if (state_q == hcb_pkg::B_WRITE) begin
      we    = 1'b1;
      waddr = {op_q.slot, op_q.col, op_q.bin};
      wdata = added[HIST_W] ? hcb_pkg::HIST_MAX : added[HIST_W-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      hcb_pkg::B_IDLE:
        if (pop_valid_i) state_d = pop_op_i.first ? hcb_pkg::B_CLEAR : hcb_pkg::B_READ;
      hcb_pkg::B_CLEAR:
        if (k_q == 4'(hcb_pkg::NUM_BINS - 1))
          state_d = op_q.emit ? hcb_pkg::B_SUM_RD : hcb_pkg::B_IDLE;
      hcb_pkg::B_READ:   state_d = hcb_pkg::B_WRITE;
      hcb_pkg::B_WRITE:  state_d = op_q.emit ? hcb_pkg::B_SUM_RD : hcb_pkg::B_IDLE;
      hcb_pkg::B_SUM_RD: state_d = hcb_pkg::B_SUM_ACC;
      hcb_pkg::B_SUM_ACC: state_d = last_elem ? hcb_pkg::B_VAL_RD : hcb_pkg::B_SUM_RD;
      hcb_pkg::B_VAL_RD: state_d = hcb_pkg::B_VAL_LD;
      hcb_pkg::B_VAL_LD: state_d = (sum_q == '0) ? hcb_pkg::B_OUT : hcb_pkg::B_DIV;
      hcb_pkg::B_DIV:    if (dstep_q == 5'(VALUE_W - 1)) state_d = hcb_pkg::B_OUT;
      hcb_pkg::B_OUT:
        if (out_free) state_d = last_elem ? hcb_pkg::B_IDLE : hcb_pkg::B_VAL_RD;
      default: state_d = hcb_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  // Element counters step through nine bins of each of the four cells.
  logic advance;
  assign advance = (state_q == hcb_pkg::B_SUM_ACC) ||
                   ((state_q == hcb_pkg::B_OUT) && out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hcb_pkg::B_IDLE;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == hcb_pkg::B_OUT) && out_free) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      hcb_pkg::B_IDLE: begin
        op_q  <= pop_op_i;
        k_q   <= '0;
        b_q   <= '0;
        c_q   <= '0;
        e_q   <= '0;
        sum_q <= '0;
      end
      hcb_pkg::B_CLEAR: k_q <= k_q + 4'd1;
      hcb_pkg::B_SUM_ACC: sum_q <= sum_q + SUM_W'(rdata_q);
      hcb_pkg::B_VAL_LD: begin
        rem_q   <= SUM_W'(num[NUM_W-1:VALUE_W]);
        nlo_q   <= num[VALUE_W-1:0];
        quo_q   <= '0;
        dstep_q <= '0;
      end
      hcb_pkg::B_DIV: begin
        dstep_q <= dstep_q + 5'd1;
        nlo_q   <= nlo_q << 1;
        if (r2 >= {1'b0, sum_q}) begin
          rem_q <= SUM_W'(r2 - {1'b0, sum_q});
          quo_q <= {quo_q[VALUE_W-2:0], 1'b1};
        end else begin
          rem_q <= r2[SUM_W-1:0];
          quo_q <= {quo_q[VALUE_W-2:0], 1'b0};
        end
      end
      hcb_pkg::B_OUT: if (out_free) begin
        block_row_o <= op_q.top;
        block_col_o <= op_q.lft;
        element_o   <= e_q;
        value_o     <= quo_q;
        last_o      <= last_elem;
      end
      default: ;
    endcase
    if (advance) begin
      if (last_elem) begin
        e_q <= '0;
        b_q <= '0;
        c_q <= '0;
      end else begin
        e_q <= e_q + 6'd1;
        if (b_q == 4'(hcb_pkg::NUM_BINS - 1)) begin
          b_q <= '0;
          c_q <= c_q + 2'd1;
        end else begin
          b_q <= b_q + 4'd1;
        end
      end
    end
  end

  `HCB_ASSERT(a_last_marks_end, clk_i, rst_ni, out_valid_o |-> (last_o == (element_o == 6'(hcb_pkg::ELEMENTS - 1))))
  `HCB_ASSERT_NEVER(a_div_nonzero, clk_i, rst_ni, (state_q == hcb_pkg::B_DIV) && (sum_q == '0))

endmodule
`default_nettype wire

/* rtl/hog_cell_block_descriptor.sv */
// HOG cell and block descriptor. Takes one padded-image pixel per item with its four
// neighbors and emits 36 L1-normalized Q1.16 values for each 2x2 block whose bottom-right
// cell completes. The front unit handles one item at a time (accept, a 13-step
// square root running alongside the two 10-step cell-position divisions, then a push
// into a two-entry queue). The back unit adds into the histogram memory by a read and a
// saturating write, or clears a cell's nine bins at its first pixel; an emission sums
// the 36 elements, then divides each by the sum in a serial divider, while the front
// keeps accepting into the queue until it is full. The 2048 x 21 bit histogram memory
// has no clearing pass; configuration should be written only while the block is idle.
`default_nettype none
module hog_cell_block_descriptor (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [1:0]  cfg_index_i,
  input  wire  [6:0]  cfg_data_i,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [7:0]  left_pixel_i,
  input  wire  [7:0]  right_pixel_i,
  input  wire  [7:0]  above_pixel_i,
  input  wire  [7:0]  below_pixel_i,
  input  wire         frame_start_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [5:0]  block_row_o,
  output logic [5:0]  block_col_o,
  output logic [5:0]  element_o,
  output logic [16:0] value_o,
  output logic        last_o
);

  hcb_pkg::cfg_t cfg_q;
  hcb_pkg::op_t  push_op, pop_op;
  logic          push_valid, push_ready, pop_valid, pop_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cell_size    <= 5'd8;
      cfg_q.cells_across <= 7'd8;
      cfg_q.cells_down   <= 7'd16;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        hcb_pkg::CFG_CELL_SIZE:    cfg_q.cell_size    <= cfg_data_i[4:0];
        hcb_pkg::CFG_CELLS_ACROSS: cfg_q.cells_across <= cfg_data_i;
        hcb_pkg::CFG_CELLS_DOWN:   cfg_q.cells_down   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  hcb_front u_front (
    .clk_i, .rst_ni,
    .cfg_i         (cfg_q),
    .in_valid_i, .in_ready_o,
    .left_pixel_i, .right_pixel_i, .above_pixel_i, .below_pixel_i, .frame_start_i,
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_op_o     (push_op)
  );

  hcb_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_valid_i  (push_valid),
    .push_ready_o  (push_ready),
    .push_op_i     (push_op),
    .pop_valid_o   (pop_valid),
    .pop_ready_i   (pop_ready),
    .pop_op_o      (pop_op)
  );

  hcb_back u_back (
    .clk_i, .rst_ni,
    .pop_valid_i   (pop_valid),
    .pop_ready_o   (pop_ready),
    .pop_op_i      (pop_op),
    .out_valid_o, .out_ready_i,
    .block_row_o, .block_col_o, .element_o, .value_o, .last_o
  );

endmodule
`default_nettype wire
